// ===== hw/rtl/resp_pkg.sv =====
`timescale 1ns / 1ps
// resp_pkg: types and character codes for the reply stream parser.
// No dependencies; used by resp_stream_parser, resp_checker and tb.
package resp_pkg;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LINE    = 3'd1,
        PH_LINE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRL_CR  = 3'd4,
        PH_TRL_LF  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_STR  = 3'd1,
        KIND_ERR  = 3'd2,
        KIND_INT  = 3'd3,
        KIND_BULK = 3'd4,
        KIND_ARR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_HEADER  = 3'd1,
        ROLE_LINE_END = 3'd2,
        ROLE_DATA    = 3'd3,
        ROLE_TRAILER = 3'd4
    } role_t;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_TYPE     = 3'd1,
        ERR_NO_LF    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_TRAILER  = 3'd4,
        ERR_OVERFLOW = 3'd5
    } err_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // number_flags bits
    localparam int FLG_NEG = 0;
    localparam int FLG_DIG = 1;
    localparam int FLG_BAD = 2;

    // tdata bit positions
    localparam int TD_PV    = 0;
    localparam int TD_LV    = 9;
    localparam int TD_ED    = 42;
    localparam int TD_NEST  = 43;
    localparam int TD_ERR   = 47;
    localparam int TD_WIDTH = 56;

    typedef struct packed {
        kind_t       value_kind;
        role_t       byte_role;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        length_valid;
        logic [31:0] length_value;
        logic        element_done;
        logic        reply_done;
        logic [3:0]  nest_level;
        err_t        error_code;
    } res_t;

endpackage

// ===== hw/rtl/resp_stream_parser.sv =====
`timescale 1ns / 1ps
// resp_stream_parser: byte-wide reply stream parser with nested array tracking.
// Depends on resp_pkg.
//
//  channel  | dir | tdata                                   | tuser            | tlast
//  s_axis   | in  | [7:0] data_byte                         | -                | -
//  m_axis   | out | payload_valid, payload_byte, length_valid,| value_kind,      | reply_done
//           |     | length_value, element_done, nest_level, | byte_role        |
//           |     | error_code                              |                  |
//
// One item per cycle unless the output stalls: each byte updates the parser state and fills
// the result register in the cycle it is accepted; its result appears on the next cycle.
// The array count stack is a register file read at the completion target.
// aresetn is synchronous; the stack contents need no clearing.
// A stalled result holds and input is taken as long as the result register
// is empty or being read.
module resp_stream_parser #(
    parameter int MAX_NEST = 8,
    parameter int LEN_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] payload_valid, [8:1] payload_byte, [9] length_valid,
    // [41:10] length_value, [42] element_done, [46:43] nest_level,
    // [49:47] error_code, [55:50] zero
    output logic [resp_pkg::TD_WIDTH-1:0] m_axis_tdata,
    output logic [5:0]                    m_axis_tuser,  // [2:0] value_kind, [5:3] byte_role
    output logic                          m_axis_tlast   // reply_done
);
    import resp_pkg::*;

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int AW = LEN_BITS;
    localparam int CW = LEN_BITS - 1;
    localparam int PW = LEN_BITS + 4;
    localparam int EW = (LEN_BITS + 1 > 32) ? LEN_BITS + 1 : 32;
    localparam logic [AW-1:0] CAP    = {1'b1, {(LEN_BITS-1){1'b0}}};
    localparam logic [AW-1:0] CAP_M1 = {1'b0, {(LEN_BITS-1){1'b1}}};
    localparam logic [PW-1:0] CAP_P  = PW'(CAP);

    phase_t        phase_reg, phase_next;
    kind_t         kind_reg, kind_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [2:0]    flg_reg, flg_next;
    logic [CW-1:0] bulk_reg, bulk_next;
    logic [DW-1:0] depth_reg, depth_next;

    logic [CW-1:0]       cnt_reg [MAX_NEST];
    logic [MAX_NEST-1:0] one_reg;

    res_t res_reg, res_next;
    logic m_valid_reg;

    logic          accept;
    logic [7:0]    b;
    logic [DW-1:0] nz_depth;
    logic [IW-1:0] dec_idx;
    logic [CW-1:0] dec_val;
    logic          fin;
    logic          push_en;
    logic          dec_en;
    logic [3:0]    digit;
    logic [PW-1:0] prod;
    logic          neg;
    logic [AW-1:0] mag;
    logic [EW-1:0] len_ext;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // highest open level whose count is not one; levels above it pop together
    always_comb begin
        nz_depth = '0;
        for (int i = 0; i < MAX_NEST; i++) begin
            if (DW'(i) < depth_reg && !one_reg[i]) begin
                nz_depth = DW'(i + 1);
            end
        end
    end

    assign dec_idx = IW'(nz_depth - 1'b1);
    assign dec_val = cnt_reg[dec_idx];
    assign digit   = 4'(b - CH_0);
    assign prod    = PW'({acc_reg, 3'b000}) + PW'({acc_reg, 1'b0}) + PW'(digit);
    assign neg     = flg_reg[FLG_NEG] && (acc_reg != '0);
    assign mag     = (!neg && acc_reg > CAP_M1) ? CAP_M1 : acc_reg;
    assign len_ext = neg ? (EW'(0) - EW'(mag)) : EW'(mag);

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        flg_next   = flg_reg;
        bulk_next  = bulk_reg;
        depth_next = depth_reg;
        fin        = 1'b0;
        push_en    = 1'b0;
        dec_en     = 1'b0;

        res_next               = '0;
        res_next.value_kind    = kind_reg;
        res_next.byte_role     = ROLE_TYPE;
        res_next.error_code    = ERR_OK;

        unique case (phase_reg)
            PH_TYPE: begin
                unique case (b)
                    CH_PLUS:   kind_next = KIND_STR;
                    CH_MINUS:  kind_next = KIND_ERR;
                    CH_COLON:  kind_next = KIND_INT;
                    CH_DOLLAR: kind_next = KIND_BULK;
                    CH_STAR:   kind_next = KIND_ARR;
                    default:   kind_next = KIND_NONE;
                endcase
                res_next.value_kind = kind_next;
                acc_next = '0;
                flg_next = '0;
                if (kind_next == KIND_NONE) begin
                    res_next.error_code = ERR_TYPE;
                    phase_next = PH_TYPE;
                    depth_next = '0;
                end else begin
                    phase_next = PH_LINE;
                end
            end
            PH_LINE: begin
                if (b == CH_CR) begin
                    res_next.byte_role = ROLE_LINE_END;
                    phase_next = PH_LINE_LF;
                end else if (kind_reg == KIND_BULK || kind_reg == KIND_ARR) begin
                    res_next.byte_role = ROLE_HEADER;
                    if (b == CH_MINUS && flg_reg == '0) begin
                        flg_next[FLG_NEG] = 1'b1;
                    end else if (b >= CH_0 && b <= CH_9) begin
                        flg_next[FLG_DIG] = 1'b1;
                        if (acc_reg >= CAP || prod > CAP_P) begin
                            acc_next = CAP;
                        end else begin
                            acc_next = AW'(prod);
                        end
                    end else begin
                        flg_next[FLG_BAD] = 1'b1;
                    end
                end else begin
                    res_next.byte_role     = ROLE_HEADER;
                    res_next.payload_valid = 1'b1;
                    res_next.payload_byte  = b;
                end
            end
            PH_LINE_LF: begin
                res_next.byte_role = ROLE_LINE_END;
                if (b != CH_LF) begin
                    res_next.error_code = ERR_NO_LF;
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    flg_next   = '0;
                    depth_next = '0;
                end else if (kind_reg == KIND_BULK || kind_reg == KIND_ARR) begin
                    acc_next = '0;
                    flg_next = '0;
                    if (flg_reg[FLG_BAD] || !flg_reg[FLG_DIG]) begin
                        res_next.error_code = ERR_LENGTH;
                        phase_next = PH_TYPE;
                        depth_next = '0;
                    end else begin
                        res_next.length_valid = 1'b1;
                        res_next.length_value = len_ext[31:0];
                        if (kind_reg == KIND_BULK) begin
                            if (neg) begin
                                phase_next = PH_TYPE;
                                fin = 1'b1;
                            end else if (mag == '0) begin
                                phase_next = PH_TRL_CR;
                            end else begin
                                bulk_next  = CW'(mag);
                                phase_next = PH_DATA;
                            end
                        end else if (neg || mag == '0) begin
                            phase_next = PH_TYPE;
                            fin = 1'b1;
                        end else if (depth_reg >= DW'(MAX_NEST)) begin
                            res_next.error_code = ERR_OVERFLOW;
                            phase_next = PH_TYPE;
                            depth_next = '0;
                        end else begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + 1'b1;
                            phase_next = PH_TYPE;
                        end
                    end
                end else begin
                    phase_next = PH_TYPE;
                    fin = 1'b1;
                end
            end
            PH_DATA: begin
                res_next.byte_role     = ROLE_DATA;
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = b;
                bulk_next = bulk_reg - 1'b1;
                if (bulk_reg == CW'(1)) begin
                    phase_next = PH_TRL_CR;
                end
            end
            PH_TRL_CR: begin
                res_next.byte_role = ROLE_TRAILER;
                if (b == CH_CR) begin
                    phase_next = PH_TRL_LF;
                end else begin
                    res_next.error_code = ERR_TRAILER;
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    flg_next   = '0;
                    depth_next = '0;
                end
            end
            PH_TRL_LF: begin
                res_next.byte_role = ROLE_TRAILER;
                if (b == CH_LF) begin
                    phase_next = PH_TYPE;
                    fin = 1'b1;
                end else begin
                    res_next.error_code = ERR_TRAILER;
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    flg_next   = '0;
                    depth_next = '0;
                end
            end
            default: begin
                phase_next = PH_TYPE;
            end
        endcase

        if (fin) begin
            res_next.element_done = 1'b1;
            depth_next = nz_depth;
            if (nz_depth == '0) begin
                res_next.reply_done = 1'b1;
            end else begin
                dec_en = 1'b1;
            end
        end

        res_next.nest_level = 4'(depth_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TYPE;
            kind_reg    <= KIND_NONE;
            acc_reg     <= '0;
            flg_reg     <= '0;
            bulk_reg    <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                acc_reg   <= acc_next;
                flg_reg   <= flg_next;
                bulk_reg  <= bulk_next;
                depth_reg <= depth_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    // count stack: push writes the new top, completion writes the decremented level
    always_ff @(posedge aclk) begin
        if (accept && push_en) begin
            cnt_reg[IW'(depth_reg)] <= CW'(mag);
            one_reg[IW'(depth_reg)] <= (mag == AW'(1));
        end else if (accept && dec_en) begin
            cnt_reg[dec_idx] <= dec_val - 1'b1;
            one_reg[dec_idx] <= (dec_val == CW'(2));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = res_reg.reply_done;
    assign m_axis_tuser  = {res_reg.byte_role, res_reg.value_kind};
    assign m_axis_tdata  = {6'b000000, res_reg.error_code, res_reg.nest_level,
                            res_reg.element_done, res_reg.length_value,
                            res_reg.length_valid, res_reg.payload_byte,
                            res_reg.payload_valid};

endmodule

// ===== hw/rtl/resp_checker.sv =====
`timescale 1ns / 1ps
// resp_checker: port-level assertions for resp_stream_parser, bound to it below.
// Depends on resp_pkg.
module resp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [resp_pkg::TD_WIDTH-1:0] m_axis_tdata,
    input logic [5:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);
    import resp_pkg::*;

    logic [2:0] kind;
    logic [2:0] role;
    logic [2:0] err;
    logic [3:0] nest;

    assign kind = m_axis_tuser[2:0];
    assign role = m_axis_tuser[5:3];
    assign err  = m_axis_tdata[TD_ERR+2:TD_ERR];
    assign nest = m_axis_tdata[TD_NEST+3:TD_NEST];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[TD_ED] && nest == 4'd0)
        else $error("reply end without completed element at top level");

    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && err != ERR_OK |->
            nest == 4'd0 && !m_axis_tdata[TD_ED] && !m_axis_tdata[TD_PV]
            && (!m_axis_tdata[TD_LV] || err == ERR_OVERFLOW))
        else $error("error item did not abandon the reply");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[TD_LV] |->
            role == ROLE_LINE_END && (kind == KIND_BULK || kind == KIND_ARR))
        else $error("length reported outside a bulk or array header end");

endmodule

bind resp_stream_parser resp_checker u_resp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for resp_stream_parser, one byte per item in, one result per byte out.
// Depends on resp_pkg and resp_stream_parser; a built-in parser predictor checks every result field.
module tb;
    import resp_pkg::*;

    localparam int          MAX_NEST    = 8;
    localparam logic [63:0] LEN_CAP     = 64'h8000_0000;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          STIM_BYTES  = 1525;
    localparam int          TAIL_BYTES  = 200;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TD_WIDTH-1:0]  m_axis_tdata;
    logic [5:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    resp_stream_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // parser state mirror
    phase_t      ph = PH_TYPE;
    kind_t       cur_kind = KIND_NONE;
    logic [63:0] num_accum = '0;
    logic [2:0]  num_flags = '0;
    logic [63:0] bulk_left = '0;
    logic [63:0] open_counts [MAX_NEST];
    int          nest_depth = 0;

    logic [7:0]  rx_bytes [$];
    res_t        pending_results [$];
    int          bytes_offered = 0;
    int          bytes_taken = 0;
    int          cycles = 0;
    int          fails = 0;
    int          results_seen = 0;
    int          replies_seen = 0;
    int          deepest = 0;
    int          err_hist [8];
    int          send_gap = 0;
    int          recv_gap = 0;
    logic        send_idle_on = 1'b1;
    logic        recv_idle_on = 1'b1;
    logic        tail_part;

    function automatic void restart_parse();
        ph = PH_TYPE;
        num_accum = '0;
        num_flags = '0;
        nest_depth = 0;
    endfunction

    // pop finished arrays; true when a top-level reply ends
    function automatic logic close_value();
        logic top_done;
        top_done = 1'b1;
        while (nest_depth > 0 && top_done) begin
            if (open_counts[nest_depth-1] > 0) open_counts[nest_depth-1] -= 64'd1;
            if (open_counts[nest_depth-1] != 0) top_done = 1'b0;
            else nest_depth--;
        end
        return top_done;
    endfunction

    function automatic res_t parse_byte(input logic [7:0] b);
        res_t        r;
        logic [63:0] d;
        logic [63:0] mag;
        logic [63:0] lval;
        logic        neg;
        r = '0;
        r.value_kind = cur_kind;
        r.byte_role = ROLE_TYPE;
        r.error_code = ERR_OK;
        case (ph)
            PH_TYPE: begin
                case (b)
                    CH_PLUS:   cur_kind = KIND_STR;
                    CH_MINUS:  cur_kind = KIND_ERR;
                    CH_COLON:  cur_kind = KIND_INT;
                    CH_DOLLAR: cur_kind = KIND_BULK;
                    CH_STAR:   cur_kind = KIND_ARR;
                    default:   cur_kind = KIND_NONE;
                endcase
                r.value_kind = cur_kind;
                if (cur_kind == KIND_NONE) begin
                    r.error_code = ERR_TYPE;
                    restart_parse();
                end else begin
                    ph = PH_LINE;
                    num_accum = '0;
                    num_flags = '0;
                end
            end
            PH_LINE: begin
                if (b == CH_CR) begin
                    r.byte_role = ROLE_LINE_END;
                    ph = PH_LINE_LF;
                end else if (cur_kind == KIND_BULK || cur_kind == KIND_ARR) begin
                    r.byte_role = ROLE_HEADER;
                    if (b == CH_MINUS && num_flags == 0) begin
                        num_flags[FLG_NEG] = 1'b1;
                    end else if (b >= CH_0 && b <= CH_9) begin
                        d = {56'd0, b - CH_0};
                        num_flags[FLG_DIG] = 1'b1;
                        if (num_accum >= LEN_CAP || num_accum > (LEN_CAP - d) / 10) begin
                            num_accum = LEN_CAP;
                        end else begin
                            num_accum = num_accum * 10 + d;
                        end
                    end else begin
                        num_flags[FLG_BAD] = 1'b1;
                    end
                end else begin
                    r.byte_role = ROLE_HEADER;
                    r.payload_valid = 1'b1;
                end
            end
            PH_LINE_LF: begin
                r.byte_role = ROLE_LINE_END;
                if (b != CH_LF) begin
                    r.error_code = ERR_NO_LF;
                    restart_parse();
                end else if (cur_kind == KIND_BULK || cur_kind == KIND_ARR) begin
                    if (num_flags[FLG_BAD] || !num_flags[FLG_DIG]) begin
                        r.error_code = ERR_LENGTH;
                        restart_parse();
                    end else begin
                        neg = num_flags[FLG_NEG] && num_accum != 0;
                        mag = num_accum;
                        if (!neg && mag > LEN_CAP - 1) mag = LEN_CAP - 1;
                        lval = neg ? 64'd0 - mag : mag;
                        r.length_valid = 1'b1;
                        r.length_value = lval[31:0];
                        num_accum = '0;
                        num_flags = '0;
                        if (cur_kind == KIND_BULK) begin
                            if (neg) begin
                                ph = PH_TYPE;
                                r.element_done = 1'b1;
                                r.reply_done = close_value();
                            end else if (mag == 0) begin
                                ph = PH_TRL_CR;
                            end else begin
                                bulk_left = mag;
                                ph = PH_DATA;
                            end
                        end else if (neg || mag == 0) begin
                            ph = PH_TYPE;
                            r.element_done = 1'b1;
                            r.reply_done = close_value();
                        end else if (nest_depth >= MAX_NEST) begin
                            r.error_code = ERR_OVERFLOW;
                            restart_parse();
                        end else begin
                            open_counts[nest_depth] = mag;
                            nest_depth++;
                            ph = PH_TYPE;
                        end
                    end
                end else begin
                    ph = PH_TYPE;
                    r.element_done = 1'b1;
                    r.reply_done = close_value();
                end
            end
            PH_DATA: begin
                r.byte_role = ROLE_DATA;
                r.payload_valid = 1'b1;
                if (bulk_left > 0) bulk_left -= 64'd1;
                if (bulk_left == 0) ph = PH_TRL_CR;
            end
            PH_TRL_CR: begin
                r.byte_role = ROLE_TRAILER;
                if (b == CH_CR) begin
                    ph = PH_TRL_LF;
                end else begin
                    r.error_code = ERR_TRAILER;
                    restart_parse();
                end
            end
            default: begin
                r.byte_role = ROLE_TRAILER;
                if (b == CH_LF) begin
                    ph = PH_TYPE;
                    r.element_done = 1'b1;
                    r.reply_done = close_value();
                end else begin
                    r.error_code = ERR_TRAILER;
                    restart_parse();
                end
            end
        endcase
        r.payload_byte = r.payload_valid ? b : 8'h00;
        r.nest_level = nest_depth[3:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            fails++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // byte stream builders
    task automatic push_byte(input logic [7:0] b);
        rx_bytes.insert(rx_bytes.size(), b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    function automatic string count_text(input int n);
        if (n > 0) begin
            if ($urandom_range(0, 4) == 0) return {"00", $sformatf("%0d", n)};
            return $sformatf("%0d", n);
        end
        if (n == 0) begin
            case ($urandom_range(0, 2))
                0:       return "-0";
                1:       return "000";
                default: return "0";
            endcase
        end
        case ($urandom_range(0, 4))
            0:       return "-42";
            1:       return "-2147483648";
            2:       return "-2147483649";
            3:       return "-99999999999999999999";
            default: return "-1";
        endcase
    endfunction

    task automatic push_line_text();
        int          n;
        logic [7:0]  c;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_CR || $urandom_range(0, 15) == 0) c = CH_LF;
            push_byte(c);
        end
        push_crlf();
    endtask

    task automatic push_bulk(input int n);
        push_byte(CH_DOLLAR);
        push_text(count_text(n));
        push_crlf();
        if (n >= 0) begin
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
            push_crlf();
        end
    endtask

    task automatic push_scalar();
        int r;
        case ($urandom_range(0, 4))
            0: begin push_byte(CH_PLUS); push_line_text(); end
            1: begin push_byte(CH_MINUS); push_line_text(); end
            2: begin push_byte(CH_COLON); push_line_text(); end
            default: begin
                r = $urandom_range(0, 9);
                if (r < 6)       push_bulk($urandom_range(1, 6));
                else if (r == 6) push_bulk($urandom_range(7, 40));
                else if (r == 7) push_bulk(0);
                else             push_bulk(-1);
            end
        endcase
    endtask

    task automatic push_array_head(input int n);
        push_byte(CH_STAR);
        push_text(count_text(n));
        push_crlf();
    endtask

    task automatic push_reply();
        int left [$];
        int n;
        left.insert(left.size(), 1);
        while (left.size() > 0) begin
            if (left[$] == 0) begin
                void'(left.pop_back());
            end else begin
                left[$] = left[$] - 1;
                if (left.size() < 6 && $urandom_range(0, 3) == 0) begin
                    n = $urandom_range(0, 4) - 1;
                    push_array_head(n);
                    if (n > 0) left.insert(left.size(), n);
                end else begin
                    push_scalar();
                end
            end
        end
    endtask

    task automatic push_broken();
        int          n;
        logic [7:0]  c;
        case ($urandom_range(0, 5))
            0: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                push_byte($urandom_range(0, 1) ? CH_PLUS : CH_STAR);
                push_text("7");
                push_byte(CH_CR);
                c = 8'($urandom_range(0, 255));
                if (c == CH_LF) c = CH_CR;
                push_byte(c);
            end
            2: begin
                push_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_STAR);
                case ($urandom_range(0, 5))
                    0:       push_text("");
                    1:       push_text("-");
                    2:       push_text("1-");
                    3:       push_text("--2");
                    4:       push_text("+3");
                    default: push_text("12a");
                endcase
                push_crlf();
            end
            3: begin
                n = $urandom_range(0, 3);
                push_byte(CH_DOLLAR);
                push_text($sformatf("%0d", n));
                push_crlf();
                for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(CH_CR);
                    if (c == CH_LF) c = 8'h00;
                end else if (c == CH_CR) begin
                    c = CH_LF;
                end
                push_byte(c);
            end
            4: begin
                push_byte(CH_STAR);
                case ($urandom_range(0, 2))
                    0:       push_text("2147483647");
                    1:       push_text("2147483648");
                    default: push_text("99999999999999");
                endcase
                push_crlf();
            end
            default: begin
                n = $urandom_range(7, 9);
                for (int i = 0; i < n; i++) push_array_head(1);
                push_scalar();
            end
        endcase
    endtask

    // drive inputs and idle both sides
    always @(negedge aclk) begin
        if (aresetn) begin
            tail_part = rx_bytes.size() < TAIL_BYTES;
            if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
            if ($urandom_range(0, 63) == 0) recv_idle_on = !recv_idle_on;
            if (!s_axis_tvalid || bytes_taken == bytes_offered) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_bytes.size() > 0 && !tail_part && send_idle_on &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else if (rx_bytes.size() > 0) begin
                    s_axis_tdata <= rx_bytes[0];
                    rx_bytes.delete(0);
                    s_axis_tvalid <= 1'b1;
                    bytes_offered++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!tail_part && recv_idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // predict on input, compare on output
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.insert(pending_results.size(), parse_byte(s_axis_tdata));
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                replies_seen += m_axis_tlast;
                err_hist[m_axis_tdata[TD_ERR +: 3]]++;
                if (m_axis_tdata[TD_NEST +: 4] > deepest) deepest = m_axis_tdata[TD_NEST +: 4];
                if (pending_results.size() == 0) begin
                    fails++;
                    $error("result item with no expectation pending");
                end else begin
                    res_t want;
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("value_kind", want.value_kind, m_axis_tuser[2:0]);
                    check_field("byte_role", want.byte_role, m_axis_tuser[5:3]);
                    check_field("payload_valid", want.payload_valid, m_axis_tdata[TD_PV]);
                    check_field("payload_byte", want.payload_byte, m_axis_tdata[TD_PV+1 +: 8]);
                    check_field("length_valid", want.length_valid, m_axis_tdata[TD_LV]);
                    check_field("length_value", want.length_value,
                                m_axis_tdata[TD_LV+1 +: 32]);
                    check_field("element_done", want.element_done, m_axis_tdata[TD_ED]);
                    check_field("reply_done", want.reply_done, m_axis_tlast);
                    check_field("nest_level", want.nest_level, m_axis_tdata[TD_NEST +: 4]);
                    check_field("error_code", want.error_code, m_axis_tdata[TD_ERR +: 3]);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) err_hist[i] = 0;
        push_text("+A\n");
        push_crlf();
        push_text("$-1");
        push_crlf();
        push_text("*0");
        push_crlf();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text("$0");
        push_crlf();
        push_crlf();
        push_text("-E");
        push_crlf();
        while (rx_bytes.size() < STIM_BYTES) begin
            if ($urandom_range(0, 7) == 0) push_broken();
            else push_reply();
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (rx_bytes.size() != 0 || bytes_taken != bytes_offered ||
               pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Parsed %0d bytes into %0d result items, %0d complete replies, nesting up to %0d",
                 bytes_taken, results_seen, replies_seen, deepest);
        $display("Errors flagged: type %0d, no LF %0d, length %0d, trailer %0d, overflow %0d",
                 err_hist[ERR_TYPE], err_hist[ERR_NO_LF], err_hist[ERR_LENGTH],
                 err_hist[ERR_TRAILER], err_hist[ERR_OVERFLOW]);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/resp_pkg.sv
hw/rtl/resp_stream_parser.sv
hw/rtl/resp_checker.sv
test/tb.sv
